@@ rtl/progressive_pixel_accumulator_assert.svh @@
// Assertion macros for the progressive pixel accumulator.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef PROGRESSIVE_PIXEL_ACCUMULATOR_ASSERT_SVH
`define PROGRESSIVE_PIXEL_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define PPA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("progressive_pixel_accumulator: invariant violated");
// Consequence must hold in the cycle after the trigger.
`define PPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("progressive_pixel_accumulator: sequence violated");
`else
`define PPA_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define PPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ppa_pkg.sv @@
// Shared constants and types of the progressive pixel accumulator.
// No dependencies.
package ppa_pkg;
    localparam int X_W        = 10;
    localparam int Y_W        = 10;
    localparam int CHAN_W     = 16;
    localparam int FW_W       = 11;
    localparam int LIN_W      = 21;
    localparam int INDEX_W    = 20;
    localparam int ABGR_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int Q_SHIFT    = 12;
    localparam int NUM_CH     = 3;
    localparam int DIV_STEPS  = 8;
    localparam int LANE_LAT   = DIV_STEPS + 1;
    localparam int FIFO_DEPTH = 32;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_COUNT_BITS = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_ACCUMULATE_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH       = 2'd1;

    localparam logic [FW_W-1:0]   FRAME_WIDTH_RESET = 11'd1024;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE      = 8'hFF;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [NUM_CH-1:0][CHAN_W-1:0] t_chan_vec;
endpackage

@@ rtl/progressive_pixel_accumulator.sv @@
// Progressive pixel accumulator, top level; uses ppa_pkg, ppa_addr, ppa_accum, ppa_lane, ppa_fifo.
// A transaction flows through ppa_addr, ppa_accum, the ppa_lane dividers and the result queue in order.
// Throughput: one pixel per cycle, but o_ready drops while all credits are taken;
// up to 32 transactions may be in flight, the depth of the result queue.
// Reset (synchronous, active low) clears control, sets frame count 1, width 1024, accumulate off;
// the sum memory is not cleared, the first frame of a run ignores what it holds.
`include "progressive_pixel_accumulator_assert.svh"

module progressive_pixel_accumulator #(
    parameter int MAX_WIDTH  = ppa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ppa_pkg::DEF_MAX_HEIGHT,
    parameter int COUNT_BITS = ppa_pkg::DEF_COUNT_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [ppa_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [ppa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Pixel input channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ppa_pkg::X_W-1:0]           i_pixel_x,
    input  logic [ppa_pkg::Y_W-1:0]           i_pixel_y,
    input  logic [ppa_pkg::CHAN_W-1:0]        i_red_in,
    input  logic [ppa_pkg::CHAN_W-1:0]        i_green_in,
    input  logic [ppa_pkg::CHAN_W-1:0]        i_blue_in,
    input  logic                              i_frame_end,
    // Result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ppa_pkg::INDEX_W-1:0]       o_pixel_index,
    output logic [ppa_pkg::ABGR_W-1:0]        o_abgr_word
);
    import ppa_pkg::*;

    localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int SUM_W     = CHAN_W + COUNT_BITS;
    localparam int TAG_W     = NUM_CH * CHAN_W + COUNT_BITS;
    localparam int CRED_W    = $clog2(FIFO_DEPTH + 1);
    localparam int RES_W     = INDEX_W + ABGR_W;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration and frame state
    logic                  r_accumulate_enable;
    logic [FW_W-1:0]       r_frame_width;
    logic [COUNT_BITS-1:0] r_frame_count;
    logic [COUNT_BITS-1:0] n_frame_count;
    logic                  frame_restart;

    // Credits count every transaction accepted whose result has not yet been
    // taken. Holding them to the queue depth means a result never finds the
    // queue full, so the pipeline itself never has to stall.
    logic [CRED_W-1:0]     r_credit;
    logic [CRED_W-1:0]     n_credit;
    logic                  in_acc;
    logic                  out_acc;

    // Address pipeline outputs
    logic                  a_valid;
    logic [ADDR_W-1:0]     a_addr;
    logic [INDEX_W-1:0]    a_index;
    logic [TAG_W-1:0]      a_tag;
    t_chan_vec             a_chan;
    logic [COUNT_BITS-1:0] a_count;

    // Accumulator outputs
    logic                         acc_valid;
    logic [INDEX_W-1:0]           acc_index;
    logic [COUNT_BITS-1:0]        acc_count;
    logic [NUM_CH-1:0][SUM_W-1:0] acc_sum;

    // Lane results and the matching index/valid delay line
    logic [NUM_CH-1:0][BYTE_W-1:0] lane_byte;
    logic                          r_lane_valid [LANE_LAT];
    logic [INDEX_W-1:0]            r_lane_index [LANE_LAT];

    logic [RES_W-1:0] push_data;
    logic [RES_W-1:0] fifo_data;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign o_ready = r_credit != CRED_W'(FIFO_DEPTH);

    // Registers are to be written by the user only while the block is idle; the
    // block itself does not enforce this. An index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accumulate_enable <= 1'b0;
            r_frame_width       <= FRAME_WIDTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACCUMULATE_ENABLE: begin
                    r_accumulate_enable <= i_cfg_data[0];
                end
                REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[FW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The frame counter moves at acceptance of the pixel that closes a frame.
    // Every pixel carries the count seen at its own acceptance, so pixels of
    // the next frame may enter right behind it. With accumulation off a frame
    // end restarts the average; with it on the counter climbs and saturates.
    assign frame_restart = in_acc && i_frame_end && !r_accumulate_enable;

    always_comb begin
        n_frame_count = r_frame_count;
        if (frame_restart) begin
            n_frame_count = COUNT_ONE;
        end else if (in_acc && i_frame_end && (r_frame_count != COUNT_MAX)) begin
            n_frame_count = r_frame_count + COUNT_ONE;
        end
    end

    assign n_credit = r_credit + CRED_W'(in_acc) - CRED_W'(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= COUNT_ONE;
            r_credit      <= '0;
        end else begin
            r_frame_count <= n_frame_count;
            r_credit      <= n_credit;
        end
    end

    // Index multiply and storage-address reduction. Color and frame count
    // ride along as a tag.
    ppa_addr #(
        .PIX_DEPTH (PIX_DEPTH),
        .ADDR_W    (ADDR_W),
        .TAG_W     (TAG_W)
    ) u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_acc),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_frame_width (r_frame_width),
        .i_tag         ({i_blue_in, i_green_in, i_red_in, r_frame_count}),
        .o_valid       (a_valid),
        .o_addr        (a_addr),
        .o_index       (a_index),
        .o_tag         (a_tag)
    );

    assign a_chan  = a_tag[TAG_W-1 -: NUM_CH*CHAN_W];
    assign a_count = a_tag[COUNT_BITS-1:0];

    // Running sums in the per-pixel memory, with forwarding for back-to-back
    // hits on the same pixel.
    ppa_accum #(
        .PIX_DEPTH  (PIX_DEPTH),
        .ADDR_W     (ADDR_W),
        .COUNT_BITS (COUNT_BITS),
        .SUM_W      (SUM_W)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (a_valid),
        .i_addr  (a_addr),
        .i_index (a_index),
        .i_count (a_count),
        .i_chan  (a_chan),
        .o_valid (acc_valid),
        .o_index (acc_index),
        .o_count (acc_count),
        .o_sum   (acc_sum)
    );

    // One divide lane per color channel, all working on the same pixel.
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        ppa_lane #(
            .COUNT_BITS (COUNT_BITS),
            .SUM_W      (SUM_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_sum   (acc_sum[ch]),
            .i_count (acc_count),
            .o_byte  (lane_byte[ch])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANE_LAT; i++) begin
                r_lane_valid[i] <= 1'b0;
            end
        end else begin
            r_lane_valid[0] <= acc_valid;
            for (int i = 1; i < LANE_LAT; i++) begin
                r_lane_valid[i] <= r_lane_valid[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane_index[0] <= acc_index;
        for (int i = 1; i < LANE_LAT; i++) begin
            r_lane_index[i] <= r_lane_index[i-1];
        end
    end

    // Merge the three lane bytes into the ABGR word with opaque alpha; the
    // queue write is the merge register.
    assign push_data = {r_lane_index[LANE_LAT-1], ALPHA_OPAQUE,
                        lane_byte[CH_BLUE], lane_byte[CH_GREEN], lane_byte[CH_RED]};

    ppa_fifo #(
        .DATA_W (RES_W),
        .DEPTH  (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_lane_valid[LANE_LAT-1]),
        .i_data  (push_data),
        .i_pop   (i_ready),
        .o_valid (o_valid),
        .o_data  (fifo_data)
    );

    assign o_pixel_index = fifo_data[RES_W-1 -: INDEX_W];
    assign o_abgr_word   = fifo_data[ABGR_W-1:0];

    // The frame counter is never zero, so the divisor is never zero.
    `PPA_ASSERT_ALWAYS(a_count_nonzero, i_clk, i_rst_n, r_frame_count != '0)
    // Credits never exceed the queue depth.
    `PPA_ASSERT_ALWAYS(a_credit_bound, i_clk, i_rst_n, r_credit <= CRED_W'(FIFO_DEPTH))
    // A queued result always belongs to an outstanding transaction.
    `PPA_ASSERT_ALWAYS(a_result_has_credit, i_clk, i_rst_n, !o_valid || (r_credit != '0))
    // Closing a frame with accumulation off restarts the average.
    `PPA_ASSERT_NEXT(a_restart, i_clk, i_rst_n, frame_restart, r_frame_count == COUNT_ONE)
endmodule

@@ rtl/ppa_addr.sv @@
// Pixel address pipeline: linear index y * width + x and its storage address
// modulo the memory depth. Depends on ppa_pkg.
module ppa_addr #(
    parameter int PIX_DEPTH = ppa_pkg::DEF_MAX_WIDTH * ppa_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W    = 20,
    parameter int TAG_W     = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [ppa_pkg::X_W-1:0]      i_pixel_x,
    input  logic [ppa_pkg::Y_W-1:0]      i_pixel_y,
    input  logic [ppa_pkg::FW_W-1:0]     i_frame_width,
    input  logic [TAG_W-1:0]             i_tag,
    output logic                         o_valid,
    output logic [ADDR_W-1:0]            o_addr,
    output logic [ppa_pkg::INDEX_W-1:0]  o_index,
    output logic [TAG_W-1:0]             o_tag
);
    import ppa_pkg::*;

    // Modulo by the depth uses a reciprocal: the estimated quotient is low
    // by at most one, so one compare and subtract finishes the remainder.
    localparam int DEP_W   = $clog2(PIX_DEPTH + 1);
    localparam int LOG_D   = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 0;
    localparam int SHIFT   = LIN_W + LOG_D;
    localparam int RECIP_W = LIN_W + 1;
    localparam int PROD_W  = LIN_W + RECIP_W;
    localparam int QD_W    = LIN_W + DEP_W;
    localparam int WIDE_W  = (LIN_W > DEP_W) ? LIN_W : DEP_W;
    localparam logic [63:0]        RECIP64 = (64'd1 << SHIFT) / 64'(PIX_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP   = RECIP64[RECIP_W-1:0];
    localparam logic [DEP_W-1:0]   DEPTH_C = DEP_W'(PIX_DEPTH);

    logic               r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic [LIN_W-1:0]   r1_prod;
    logic [X_W-1:0]     r1_x;
    logic [LIN_W-1:0]   r2_lin, r3_lin, r4_lin;
    logic [PROD_W-1:0]  r3_qm;
    logic [QD_W-1:0]    r4_qd;
    logic [ADDR_W-1:0]  r5_addr;
    logic [INDEX_W-1:0] r5_index;
    logic [TAG_W-1:0]   r1_tag, r2_tag, r3_tag, r4_tag, r5_tag;

    logic [LIN_W-1:0]   quot;
    logic [LIN_W-1:0]   rem;
    logic [WIDE_W-1:0]  rem_wide;
    logic [WIDE_W-1:0]  rem_mod;

    assign quot     = LIN_W'(r3_qm >> SHIFT);
    assign rem      = r4_lin - r4_qd[LIN_W-1:0];
    assign rem_wide = WIDE_W'(rem);
    assign rem_mod  = (rem_wide >= WIDE_W'(DEPTH_C)) ? rem_wide - WIDE_W'(DEPTH_C) : rem_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod  <= LIN_W'(i_pixel_y) * LIN_W'(i_frame_width);
        r1_x     <= i_pixel_x;
        r1_tag   <= i_tag;
        r2_lin   <= r1_prod + LIN_W'(r1_x);
        r2_tag   <= r1_tag;
        r3_qm    <= PROD_W'(r2_lin) * PROD_W'(RECIP);
        r3_lin   <= r2_lin;
        r3_tag   <= r2_tag;
        r4_qd    <= QD_W'(quot) * QD_W'(DEPTH_C);
        r4_lin   <= r3_lin;
        r4_tag   <= r3_tag;
        r5_addr  <= ADDR_W'(rem_mod);
        r5_index <= r4_lin[INDEX_W-1:0];
        r5_tag   <= r4_tag;
    end

    assign o_valid = r5_valid;
    assign o_addr  = r5_addr;
    assign o_index = r5_index;
    assign o_tag   = r5_tag;
endmodule

@@ rtl/ppa_accum.sv @@
// Per-pixel sum memory with read-modify-write and saturating add for all
// three channels. Depends on ppa_pkg.
module ppa_accum #(
    parameter int PIX_DEPTH  = ppa_pkg::DEF_MAX_WIDTH * ppa_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W     = 20,
    parameter int COUNT_BITS = ppa_pkg::DEF_COUNT_BITS,
    parameter int SUM_W      = ppa_pkg::CHAN_W + ppa_pkg::DEF_COUNT_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic [ADDR_W-1:0]                       i_addr,
    input  logic [ppa_pkg::INDEX_W-1:0]             i_index,
    input  logic [COUNT_BITS-1:0]                   i_count,
    input  ppa_pkg::t_chan_vec                      i_chan,
    output logic                                    o_valid,
    output logic [ppa_pkg::INDEX_W-1:0]             o_index,
    output logic [COUNT_BITS-1:0]                   o_count,
    output logic [ppa_pkg::NUM_CH-1:0][SUM_W-1:0]   o_sum
);
    import ppa_pkg::*;

    localparam int TOT_W = SUM_W + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic [NUM_CH-1:0][SUM_W-1:0] r_mem [PIX_DEPTH];
    logic [NUM_CH-1:0][SUM_W-1:0] r_rdata;

    logic                         r_s_valid;
    logic [ADDR_W-1:0]            r_s_addr;
    logic [INDEX_W-1:0]           r_s_index;
    logic [COUNT_BITS-1:0]        r_s_count;
    t_chan_vec                    r_s_chan;
    logic                         r_fwd_hit;
    logic [NUM_CH-1:0][SUM_W-1:0] r_fwd_sum;

    logic                         r_o_valid;
    logic [INDEX_W-1:0]           r_o_index;
    logic [COUNT_BITS-1:0]        r_o_count;
    logic [NUM_CH-1:0][SUM_W-1:0] r_o_sum;

    logic [NUM_CH-1:0][SUM_W-1:0] prev;
    logic [NUM_CH-1:0][TOT_W-1:0] total;
    logic [NUM_CH-1:0][SUM_W-1:0] n_sum;

    // The first frame of a run ignores the stored sum. A pixel right behind one
    // on the same address reads stale memory, so it takes the sum just computed
    // instead.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_s_count == COUNT_ONE) begin
                prev[c] = '0;
            end else if (r_fwd_hit) begin
                prev[c] = r_fwd_sum[c];
            end else begin
                prev[c] = r_rdata[c];
            end
            total[c] = TOT_W'(prev[c]) + TOT_W'(r_s_chan[c]);
            n_sum[c] = total[c][SUM_W] ? {SUM_W{1'b1}} : total[c][SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_valid) begin
            r_mem[r_s_addr] <= n_sum;
        end
        r_rdata <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_s_valid <= i_valid;
            r_fwd_hit <= i_valid && r_s_valid && (i_addr == r_s_addr);
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_addr  <= i_addr;
        r_s_index <= i_index;
        r_s_count <= i_count;
        r_s_chan  <= i_chan;
        r_fwd_sum <= n_sum;
        r_o_index <= r_s_index;
        r_o_count <= r_s_count;
        r_o_sum   <= n_sum;
    end

    assign o_valid = r_o_valid;
    assign o_index = r_o_index;
    assign o_count = r_o_count;
    assign o_sum   = r_o_sum;
endmodule

@@ rtl/ppa_lane.sv @@
// One channel lane: clamps the mean to 1.0 and forms floor(255 * sum /
// (4096 * count)) one quotient bit per stage. Depends on ppa_pkg.
module ppa_lane #(
    parameter int COUNT_BITS = ppa_pkg::DEF_COUNT_BITS,
    parameter int SUM_W      = ppa_pkg::CHAN_W + ppa_pkg::DEF_COUNT_BITS
) (
    input  logic                        i_clk,
    input  logic [SUM_W-1:0]            i_sum,
    input  logic [COUNT_BITS-1:0]       i_count,
    output logic [ppa_pkg::BYTE_W-1:0]  o_byte
);
    import ppa_pkg::*;

    localparam int NUM_W = SUM_W + BYTE_W;
    localparam int DV_W  = COUNT_BITS + Q_SHIFT;

    logic [NUM_W-1:0]  r_rem [DIV_STEPS];
    logic [DV_W-1:0]   r_dv  [DIV_STEPS];
    logic [BYTE_W-1:0] r_q   [DIV_STEPS+1];
    logic              r_sat [DIV_STEPS+1];

    logic [DV_W-1:0]   full;
    logic [NUM_W-1:0]  num;

    assign full = {i_count, {Q_SHIFT{1'b0}}};
    assign num  = (NUM_W'(i_sum) << BYTE_W) - NUM_W'(i_sum);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= num;
        r_dv[0]  <= full;
        r_sat[0] <= NUM_W'(i_sum) >= NUM_W'(full);
        r_q[0]   <= '0;
    end

    // Below saturation the quotient is under 256, so eight restoring steps
    // from the top bit down are exact.
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        localparam int BIT = DIV_STEPS - k;
        logic [NUM_W-1:0] trial;
        logic             take;

        assign trial = NUM_W'(r_dv[k-1]) << BIT;
        assign take  = r_rem[k-1] >= trial;

        always_ff @(posedge i_clk) begin
            r_q[k]   <= r_q[k-1] | (take ? (BYTE_W'(1) << BIT) : BYTE_W'(0));
            r_sat[k] <= r_sat[k-1];
        end

        if (k < DIV_STEPS) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k] <= take ? r_rem[k-1] - trial : r_rem[k-1];
                r_dv[k]  <= r_dv[k-1];
            end
        end
    end

    assign o_byte = r_sat[DIV_STEPS] ? {BYTE_W{1'b1}} : r_q[DIV_STEPS];
endmodule

@@ rtl/ppa_fifo.sv @@
// Result queue: holds finished pixels until the consumer takes them.
// DEPTH must be a power of two. Takes its default sizes from ppa_pkg.
module ppa_fifo #(
    parameter int DATA_W = ppa_pkg::INDEX_W + ppa_pkg::ABGR_W,
    parameter int DEPTH  = ppa_pkg::FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_pop;

    assign o_valid = r_count != '0;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end
endmodule
